>>> rtl/first_fit_heap_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define FFHA_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("first_fit_heap_allocator: assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define FFHA_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("first_fit_heap_allocator: assertion failed");

`endif

>>> rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Sizes, constants and codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

	localparam int unsigned FREE_ENTRIES  = 64;
	localparam int unsigned ALLOC_ENTRIES = 64;
	localparam int unsigned ADDR_BITS     = 32;

	localparam int unsigned FREE_AW  = $clog2(FREE_ENTRIES);
	localparam int unsigned LINK_W   = $clog2(FREE_ENTRIES + 1);
	localparam int unsigned ALLOC_AW = $clog2(ALLOC_ENTRIES);
	localparam int unsigned ADDR_W   = ADDR_BITS;
	localparam int unsigned LEN_W    = ADDR_BITS + 1;
	localparam int unsigned CALC_W   = (ADDR_BITS + 2 > 36) ? ADDR_BITS + 2 : 36;
	localparam int unsigned UA_W     = (ADDR_BITS > 32) ? ADDR_BITS : 32;
	localparam int unsigned OFF_W    = 33;
	localparam int unsigned NEED_W   = 26;
	localparam int unsigned SIZE_W   = 24;
	localparam int unsigned OUT_W    = 32;
	localparam int unsigned GL_W     = 5;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned STATUS_W  = 3;

	localparam int unsigned MIN_CHUNK = 24;
	localparam int unsigned HDR_BYTES = 8;
	localparam int unsigned ALIGN     = 8;

	localparam logic [GL_W-1:0] GL_MIN   = GL_W'(3);
	localparam logic [GL_W-1:0] GL_MAX   = GL_W'(24);
	localparam logic [GL_W-1:0] GL_RESET = GL_W'(22);
	localparam logic [31:0]     HEAP_BASE_RESET = 32'd65536;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(FREE_ENTRIES);
	localparam logic [CALC_W-1:0] ADDR_LIMIT = CALC_W'(1) << ADDR_BITS;
	localparam logic [CALC_W-1:0] OFF_MAX = (CALC_W'(1) << OFF_W) - CALC_W'(1);

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_GRANULE_LOG2 = CFG_IDX_W'(1);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NULL      = 3'd1,
		ST_FULL      = 3'd2,
		ST_EXHAUSTED = 3'd3,
		ST_UNKNOWN   = 3'd4
	} status_t;

endpackage

`default_nettype wire

>>> rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Explicit free list allocator, first fit from the list head, with coalescing.
// ----------------------------------------------------------------------------
// One request is worked on at a time. An allocate request walks the free
// list from the head and waits for each read of the free table memory. A
// free request scans both tables one entry per cycle through their single
// read port. Requests with a null size or address go straight to the
// S_FIN state. Valid bits live in flip-flops, so no clearing pass follows
// reset. A finished result waits in the output register while the next
// request is taken.
`default_nettype none

module first_fit_heap_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [ffha_pkg::SIZE_W-1:0]     req_size,
	input  logic [31:0]                     user_addr,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ffha_pkg::STATUS_W-1:0]   status,
	output logic [ffha_pkg::OUT_W-1:0]      result_addr,
	output logic [ffha_pkg::OUT_W-1:0]      chunk_bytes,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ffha_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);
	import ffha_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_WALK_WAIT, S_WALK_CHK, S_GROW, S_GROW_CHK, S_A_SPLIT,
		S_UNL_SET, S_UNL_WAIT, S_UNL_DO, S_PUSH1, S_PUSH2, S_FSCAN_A,
		S_FSCAN_F, S_F_DECIDE, S_F_RIGHT, S_F_MERGE, S_FIN
	} state_t;

	localparam logic [FREE_AW-1:0]  F_LAST = FREE_AW'(FREE_ENTRIES - 1);
	localparam logic [ALLOC_AW-1:0] A_LAST = ALLOC_AW'(ALLOC_ENTRIES - 1);

	function automatic logic [LINK_W-1:0] free_first(input logic [FREE_ENTRIES-1:0] u);
		logic [LINK_W-1:0] r;
		r = NIL;
		for (int i = FREE_ENTRIES - 1; i >= 0; i--) begin
			if (!u[i]) r = LINK_W'(i);
		end
		return r;
	endfunction

	function automatic logic [ALLOC_AW-1:0] alloc_first(input logic [ALLOC_ENTRIES-1:0] v);
		logic [ALLOC_AW-1:0] r;
		r = '0;
		for (int i = ALLOC_ENTRIES - 1; i >= 0; i--) begin
			if (!v[i]) r = ALLOC_AW'(i);
		end
		return r;
	endfunction

	function automatic logic [OUT_W-1:0] out32(input logic [CALC_W-1:0] v);
		return v[OUT_W-1:0];
	endfunction

	// Free chunk table and handed-out chunk table.
	logic [ADDR_W-1:0] fs_mem [FREE_ENTRIES];
	logic [LEN_W-1:0]  fl_mem [FREE_ENTRIES];
	logic [LINK_W-1:0] fn_mem [FREE_ENTRIES];
	logic [LINK_W-1:0] fp_mem [FREE_ENTRIES];
	logic [ADDR_W-1:0] as_mem [ALLOC_ENTRIES];
	logic [LEN_W-1:0]  al_mem [ALLOC_ENTRIES];

	logic [ADDR_W-1:0] fs_rd;
	logic [LEN_W-1:0]  fl_rd;
	logic [LINK_W-1:0] fn_rd;
	logic [LINK_W-1:0] fp_rd;
	logic [ADDR_W-1:0] as_rd;
	logic [LEN_W-1:0]  al_rd;

	state_t                state_q;
	state_t                ret_q;
	logic [LINK_W-1:0]     head_q;
	logic [FREE_ENTRIES-1:0]  used_q;
	logic [ALLOC_ENTRIES-1:0] avalid_q;
	logic [OFF_W-1:0]      grow_off_q;
	logic [31:0]           heap_base_q;
	logic [GL_W-1:0]       gran_q;
	logic [NEED_W-1:0]     need_q;
	logic [ALLOC_AW-1:0]   a_q;
	logic [FREE_AW-1:0]    hit_q;
	logic [CALC_W-1:0]     base_q;
	logic [LEN_W-1:0]      len_q;
	logic [NEED_W-1:0]     region_q;
	logic [ADDR_W-1:0]     chunk_q;
	logic [CALC_W-1:0]     cend_q;
	logic [LINK_W-1:0]     left_q;
	logic [LINK_W-1:0]     right_q;
	logic [ADDR_W-1:0]     lstart_q;
	logic [LEN_W-1:0]      llen_q;
	logic [LEN_W-1:0]      rlen_q;
	logic [FREE_AW-1:0]    unl_q;
	logic [FREE_AW-1:0]    push_slot_q;
	logic [ADDR_W-1:0]     push_start_q;
	logic [LEN_W-1:0]      push_len_q;
	logic [FREE_AW-1:0]    fr_addr_q;
	logic [ALLOC_AW-1:0]   al_addr_q;
	logic [FREE_AW-1:0]    fr_addr_s1;
	logic [ALLOC_AW-1:0]   al_addr_s1;
	logic                  scan_vld_s1;
	status_t               res_status_q;
	logic [OUT_W-1:0]      res_addr_q;
	logic [OUT_W-1:0]      res_bytes_q;
	logic                  out_valid_q;
	status_t               status_q;
	logic [OUT_W-1:0]      result_addr_q;
	logic [OUT_W-1:0]      chunk_bytes_q;

	logic [UA_W-1:0]   chunk_calc;
	logic [NEED_W-1:0] need_sum;
	logic [NEED_W-1:0] need_calc;
	logic [GL_W-1:0]   gl;
	logic [NEED_W-1:0] gmask;
	logic [NEED_W-1:0] region_calc;
	logic [LINK_W-1:0] empty_slot;
	logic              alloc_full;
	logic [CALC_W-1:0] rem;
	logic              split;
	logic [CALC_W-1:0] sum_bn;
	logic [CALC_W-1:0] addr8;
	logic [CALC_W-1:0] e_end;
	logic [LEN_W-1:0]  mlen;
	logic [ADDR_W-1:0] mstart;
	logic [LINK_W-1:0] mslot;

	logic              fn_we;
	logic [FREE_AW-1:0] fn_wa;
	logic [LINK_W-1:0] fn_wd;
	logic              fp_we;
	logic [FREE_AW-1:0] fp_wa;
	logic [LINK_W-1:0] fp_wd;
	logic              pk_we;
	logic              am_we;
	logic [LEN_W-1:0]  am_len;

	assign in_ready    = (state_q == S_IDLE);
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign result_addr = result_addr_q;
	assign chunk_bytes = chunk_bytes_q;

	always_comb begin
		chunk_calc = UA_W'(user_addr) - UA_W'(HDR_BYTES);
		need_sum = (NEED_W'(req_size) + NEED_W'(HDR_BYTES + ALIGN - 1)) &
			~NEED_W'(ALIGN - 1);
		need_calc = (need_sum < NEED_W'(MIN_CHUNK)) ? NEED_W'(MIN_CHUNK) : need_sum;
		if (gran_q < GL_MIN) begin
			gl = GL_MIN;
		end else if (gran_q > GL_MAX) begin
			gl = GL_MAX;
		end else begin
			gl = gran_q;
		end
		gmask = (NEED_W'(1) << gl) - NEED_W'(1);
		region_calc = (need_q + gmask) & ~gmask;
		empty_slot = free_first(used_q);
		alloc_full = &avalid_q;
		rem = CALC_W'(len_q) - CALC_W'(need_q);
		split = (rem >= CALC_W'(MIN_CHUNK));
		sum_bn = base_q + CALC_W'(need_q);
		addr8 = base_q + CALC_W'(HDR_BYTES);
		e_end = CALC_W'(fs_rd) + CALC_W'(fl_rd);
		mlen = len_q + ((left_q != NIL) ? llen_q : '0) + ((right_q != NIL) ? rlen_q : '0);
		mstart = (left_q != NIL) ? lstart_q : chunk_q;
		if (left_q != NIL) begin
			mslot = left_q;
		end else if (right_q != NIL) begin
			mslot = right_q;
		end else begin
			mslot = empty_slot;
		end
	end

	always_comb begin
		fn_we = 1'b0;
		fn_wa = push_slot_q;
		fn_wd = head_q;
		fp_we = 1'b0;
		fp_wa = push_slot_q;
		fp_wd = NIL;
		pk_we = 1'b0;
		am_we = 1'b0;
		am_len = split ? LEN_W'(need_q) : len_q;
		case (state_q)
			S_PUSH1: begin
				pk_we = 1'b1;
				fn_we = 1'b1;
				fp_we = 1'b1;
			end
			S_PUSH2: begin
				fp_we = (head_q != NIL);
				fp_wa = head_q[FREE_AW-1:0];
				fp_wd = LINK_W'(push_slot_q);
			end
			S_UNL_DO: begin
				fn_we = (fp_rd != NIL);
				fn_wa = fp_rd[FREE_AW-1:0];
				fn_wd = fn_rd;
				fp_we = (fn_rd != NIL);
				fp_wa = fn_rd[FREE_AW-1:0];
				fp_wd = fp_rd;
			end
			S_A_SPLIT: begin
				am_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pk_we) begin
			fs_mem[push_slot_q] <= push_start_q;
			fl_mem[push_slot_q] <= push_len_q;
		end
		fs_rd <= fs_mem[fr_addr_q];
		fl_rd <= fl_mem[fr_addr_q];
	end

	always_ff @(posedge clk) begin
		if (fn_we) begin
			fn_mem[fn_wa] <= fn_wd;
		end
		fn_rd <= fn_mem[fr_addr_q];
	end

	always_ff @(posedge clk) begin
		if (fp_we) begin
			fp_mem[fp_wa] <= fp_wd;
		end
		fp_rd <= fp_mem[fr_addr_q];
	end

	always_ff @(posedge clk) begin
		if (am_we) begin
			as_mem[a_q] <= base_q[ADDR_W-1:0];
			al_mem[a_q] <= am_len;
		end
		as_rd <= as_mem[al_addr_q];
		al_rd <= al_mem[al_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			head_q      <= NIL;
			used_q      <= '0;
			avalid_q    <= '0;
			grow_off_q  <= '0;
			heap_base_q <= HEAP_BASE_RESET;
			gran_q      <= GL_RESET;
			scan_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			fr_addr_s1  <= fr_addr_q;
			al_addr_s1  <= al_addr_q;
			scan_vld_s1 <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				if (cfg_index == CFG_HEAP_BASE) begin
					heap_base_q <= cfg_data;
				end else if (cfg_index == CFG_GRANULE_LOG2) begin
					gran_q <= cfg_data[GL_W-1:0];
				end
			end
			case (state_q)
				S_IDLE: begin
					res_addr_q  <= '0;
					res_bytes_q <= '0;
					if (in_valid) begin
						if (mode) begin
							if (user_addr == '0) begin
								res_status_q <= ST_NULL;
								state_q      <= S_FIN;
							end else begin
								chunk_q   <= chunk_calc[ADDR_W-1:0];
								al_addr_q <= '0;
								state_q   <= S_FSCAN_A;
							end
						end else if (req_size == '0) begin
							res_status_q <= ST_NULL;
							state_q      <= S_FIN;
						end else if (alloc_full) begin
							res_status_q <= ST_FULL;
							state_q      <= S_FIN;
						end else begin
							a_q    <= alloc_first(avalid_q);
							need_q <= need_calc;
							if (head_q == NIL) begin
								state_q <= S_GROW;
							end else begin
								fr_addr_q <= head_q[FREE_AW-1:0];
								state_q   <= S_WALK_WAIT;
							end
						end
					end
				end
				S_WALK_WAIT: begin
					state_q <= S_WALK_CHK;
				end
				S_WALK_CHK: begin
					if (CALC_W'(fl_rd) >= CALC_W'(need_q)) begin
						hit_q   <= fr_addr_q;
						base_q  <= CALC_W'(fs_rd);
						len_q   <= fl_rd;
						ret_q   <= S_A_SPLIT;
						state_q <= S_UNL_DO;
					end else if (fn_rd == NIL) begin
						state_q <= S_GROW;
					end else begin
						fr_addr_q <= fn_rd[FREE_AW-1:0];
						state_q   <= S_WALK_WAIT;
					end
				end
				S_GROW: begin
					if (empty_slot == NIL) begin
						res_status_q <= ST_FULL;
						state_q      <= S_FIN;
					end else begin
						hit_q    <= empty_slot[FREE_AW-1:0];
						region_q <= region_calc;
						base_q   <= CALC_W'(heap_base_q) + CALC_W'(grow_off_q);
						state_q  <= S_GROW_CHK;
					end
				end
				S_GROW_CHK: begin
					if ((base_q + CALC_W'(region_q) > ADDR_LIMIT) ||
						(CALC_W'(grow_off_q) + CALC_W'(region_q) > OFF_MAX)) begin
						res_status_q <= ST_EXHAUSTED;
						state_q      <= S_FIN;
					end else begin
						grow_off_q <= grow_off_q + OFF_W'(region_q);
						len_q      <= LEN_W'(region_q);
						state_q    <= S_A_SPLIT;
					end
				end
				S_A_SPLIT: begin
					avalid_q[a_q] <= 1'b1;
					res_status_q  <= ST_OK;
					res_addr_q    <= out32(addr8);
					res_bytes_q   <= out32(CALC_W'(am_len));
					if (split) begin
						push_slot_q  <= hit_q;
						push_start_q <= sum_bn[ADDR_W-1:0];
						push_len_q   <= rem[LEN_W-1:0];
						state_q      <= S_PUSH1;
					end else begin
						used_q[hit_q] <= 1'b0;
						state_q       <= S_FIN;
					end
				end
				S_UNL_SET: begin
					fr_addr_q <= unl_q;
					state_q   <= S_UNL_WAIT;
				end
				S_UNL_WAIT: begin
					state_q <= S_UNL_DO;
				end
				S_UNL_DO: begin
					if (fp_rd == NIL) begin
						head_q <= fn_rd;
					end
					state_q <= ret_q;
				end
				S_PUSH1: begin
					used_q[push_slot_q] <= 1'b1;
					state_q             <= S_PUSH2;
				end
				S_PUSH2: begin
					head_q  <= LINK_W'(push_slot_q);
					state_q <= S_FIN;
				end
				S_FSCAN_A: begin
					scan_vld_s1 <= 1'b1;
					if (al_addr_q != A_LAST) begin
						al_addr_q <= al_addr_q + ALLOC_AW'(1);
					end
					if (scan_vld_s1) begin
						if (avalid_q[al_addr_s1] && (as_rd == chunk_q)) begin
							a_q         <= al_addr_s1;
							len_q       <= al_rd;
							cend_q      <= CALC_W'(as_rd) + CALC_W'(al_rd);
							fr_addr_q   <= '0;
							left_q      <= NIL;
							right_q     <= NIL;
							scan_vld_s1 <= 1'b0;
							state_q     <= S_FSCAN_F;
						end else if (al_addr_s1 == A_LAST) begin
							res_status_q <= ST_UNKNOWN;
							scan_vld_s1  <= 1'b0;
							state_q      <= S_FIN;
						end
					end
				end
				S_FSCAN_F: begin
					scan_vld_s1 <= 1'b1;
					if (fr_addr_q != F_LAST) begin
						fr_addr_q <= fr_addr_q + FREE_AW'(1);
					end
					if (scan_vld_s1) begin
						if (used_q[fr_addr_s1]) begin
							if ((left_q == NIL) && (e_end == CALC_W'(chunk_q))) begin
								left_q   <= LINK_W'(fr_addr_s1);
								lstart_q <= fs_rd;
								llen_q   <= fl_rd;
							end else if ((right_q == NIL) && (CALC_W'(fs_rd) == cend_q)) begin
								right_q <= LINK_W'(fr_addr_s1);
								rlen_q  <= fl_rd;
							end
						end
						if (fr_addr_s1 == F_LAST) begin
							scan_vld_s1 <= 1'b0;
							state_q     <= S_F_DECIDE;
						end
					end
				end
				S_F_DECIDE: begin
					if ((left_q == NIL) && (right_q == NIL) && (empty_slot == NIL)) begin
						res_status_q <= ST_FULL;
						state_q      <= S_FIN;
					end else begin
						avalid_q[a_q] <= 1'b0;
						if (left_q != NIL) begin
							unl_q   <= left_q[FREE_AW-1:0];
							ret_q   <= S_F_RIGHT;
							state_q <= S_UNL_SET;
						end else begin
							state_q <= S_F_RIGHT;
						end
					end
				end
				S_F_RIGHT: begin
					if (right_q != NIL) begin
						unl_q   <= right_q[FREE_AW-1:0];
						ret_q   <= S_F_MERGE;
						state_q <= S_UNL_SET;
					end else begin
						state_q <= S_F_MERGE;
					end
				end
				S_F_MERGE: begin
					if ((left_q != NIL) && (right_q != NIL)) begin
						used_q[right_q[FREE_AW-1:0]] <= 1'b0;
					end
					push_slot_q  <= mslot[FREE_AW-1:0];
					push_start_q <= mstart;
					push_len_q   <= mlen;
					res_status_q <= ST_OK;
					res_addr_q   <= '0;
					res_bytes_q  <= out32(CALC_W'(mlen));
					state_q      <= S_PUSH1;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						status_q      <= res_status_q;
						result_addr_q <= res_addr_q;
						chunk_bytes_q <= res_bytes_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "first_fit_heap_allocator_macros.svh"

	`FFHA_ASSERT_IMP(a_head_used, head_q != NIL, used_q[head_q[FREE_AW-1:0]])
	`FFHA_ASSERT_IMP(a_err_zero, out_valid_q && (status_q != ST_OK), (result_addr == '0) && (chunk_bytes == '0))
	`FFHA_ASSERT_NXT(a_push_used, state_q == S_PUSH1, used_q[push_slot_q] && (state_q == S_PUSH2))

endmodule

`default_nettype wire

>>> sim/first_fit_heap_allocator_tb.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Checks allocate and free results against a shadow copy of the heap tables.
// ----------------------------------------------------------------------------
// Each accepted request is run through a shadow of the free list, the
// allocation table and the bump pointer. Every result beat is compared
// field by field with the oldest expected result. Directed requests cover
// the edge cases. Random traffic then runs under several heap settings,
// with bursty input, a stalling output and one long output hold-off.
`default_nettype none

module first_fit_heap_allocator_tb;

	import ffha_pkg::*;

	typedef struct {
		status_t     st;
		logic [31:0] addr;
		logic [31:0] bytes;
	} heap_result_t;

	class heap_scoreboard;
		localparam int EMPTY = FREE_ENTRIES;
		localparam logic [63:0] SPACE_END = 64'h1_0000_0000;
		localparam logic [63:0] GROW_MAX = (64'd1 << 33) - 64'd1;

		logic [63:0] hole_start[FREE_ENTRIES];
		logic [63:0] hole_len[FREE_ENTRIES];
		int          hole_next[FREE_ENTRIES];
		int          hole_prev[FREE_ENTRIES];
		bit          hole_used[FREE_ENTRIES];
		int          head;
		logic [63:0] live_start[ALLOC_ENTRIES];
		logic [63:0] live_len[ALLOC_ENTRIES];
		bit          live[ALLOC_ENTRIES];
		logic [63:0] grown;
		logic [63:0] base_reg;
		int          gran_reg;
		heap_result_t pending_q[$];
		int          errors;

		function new();
			foreach (hole_used[i]) begin
				hole_used[i] = 0;
				hole_next[i] = EMPTY;
				hole_prev[i] = EMPTY;
			end
			foreach (live[i])
				live[i] = 0;
			head = EMPTY;
			grown = 0;
			base_reg = {32'd0, HEAP_BASE_RESET};
			gran_reg = int'(GL_RESET);
			errors = 0;
		endfunction

		function void set_config(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			if (idx == CFG_HEAP_BASE)
				base_reg = {32'd0, data};
			else
				gran_reg = int'(data[4:0]);
		endfunction

		function void detach(int i);
			int p, n;
			p = hole_prev[i];
			n = hole_next[i];
			if (p < EMPTY)
				hole_next[p] = n;
			else
				head = n;
			if (n < EMPTY)
				hole_prev[n] = p;
			hole_next[i] = EMPTY;
			hole_prev[i] = EMPTY;
		endfunction

		function void push_front(int i);
			hole_prev[i] = EMPTY;
			hole_next[i] = head;
			if (head < EMPTY)
				hole_prev[head] = i;
			head = i;
			hole_used[i] = 1;
		endfunction

		function int spare_slot();
			for (int i = 0; i < EMPTY; i++)
				if (!hole_used[i])
					return i;
			return EMPTY;
		endfunction

		function heap_result_t allocate(logic [23:0] size);
			heap_result_t r;
			logic [63:0] need, len, region, b;
			int a, cur, hit, g;
			r = '{ST_OK, 32'd0, 32'd0};
			if (size == 0) begin
				r.st = ST_NULL;
				return r;
			end
			for (a = 0; a < ALLOC_ENTRIES; a++)
				if (!live[a])
					break;
			if (a >= ALLOC_ENTRIES) begin
				r.st = ST_FULL;
				return r;
			end
			need = ({40'd0, size} + 64'd15) & ~64'd7;
			if (need < 64'(MIN_CHUNK))
				need = 64'(MIN_CHUNK);
			hit = EMPTY;
			cur = head;
			for (int s = 0; cur < EMPTY && s < EMPTY; s++) begin
				if (hole_len[cur] >= need) begin
					hit = cur;
					break;
				end
				cur = hole_next[cur];
			end
			if (hit >= EMPTY) begin
				hit = spare_slot();
				if (hit >= EMPTY) begin
					r.st = ST_FULL;
					return r;
				end
				g = gran_reg < 3 ? 3 : (gran_reg > 24 ? 24 : gran_reg);
				region = ((need + (64'd1 << g) - 64'd1) >> g) << g;
				b = base_reg + grown;
				if (b + region > SPACE_END || grown + region > GROW_MAX) begin
					r.st = ST_EXHAUSTED;
					return r;
				end
				grown += region;
				hole_start[hit] = b;
				hole_len[hit] = region;
				push_front(hit);
			end
			b = hole_start[hit];
			len = hole_len[hit];
			detach(hit);
			if (len - need >= 64'(MIN_CHUNK)) begin
				hole_start[hit] = b + need;
				hole_len[hit] = len - need;
				push_front(hit);
				len = need;
			end else begin
				hole_used[hit] = 0;
			end
			live_start[a] = b;
			live_len[a] = len;
			live[a] = 1;
			r.addr = 32'(b + HDR_BYTES);
			r.bytes = 32'(len);
			return r;
		endfunction

		function heap_result_t release_chunk(logic [31:0] ua);
			heap_result_t r;
			logic [63:0] chunk, start, len;
			int a, left, right, slot;
			r = '{ST_OK, 32'd0, 32'd0};
			if (ua == 0) begin
				r.st = ST_NULL;
				return r;
			end
			chunk = {32'd0, ua - 32'd8};
			for (a = 0; a < ALLOC_ENTRIES; a++)
				if (live[a] && live_start[a] == chunk)
					break;
			if (a >= ALLOC_ENTRIES) begin
				r.st = ST_UNKNOWN;
				return r;
			end
			len = live_len[a];
			left = EMPTY;
			right = EMPTY;
			for (int i = 0; i < EMPTY; i++) begin
				if (!hole_used[i])
					continue;
				if (left >= EMPTY && hole_start[i] + hole_len[i] == chunk)
					left = i;
				else if (right >= EMPTY && hole_start[i] == chunk + len)
					right = i;
			end
			if (left >= EMPTY && right >= EMPTY && spare_slot() >= EMPTY) begin
				r.st = ST_FULL;
				return r;
			end
			live[a] = 0;
			start = chunk;
			slot = EMPTY;
			if (left < EMPTY) begin
				detach(left);
				start = hole_start[left];
				len += hole_len[left];
				slot = left;
			end
			if (right < EMPTY) begin
				detach(right);
				len += hole_len[right];
				if (slot < EMPTY)
					hole_used[right] = 0;
				else
					slot = right;
			end
			if (slot >= EMPTY)
				slot = spare_slot();
			hole_start[slot] = start;
			hole_len[slot] = len;
			push_front(slot);
			r.bytes = 32'(len);
			return r;
		endfunction

		function void note_request(logic m, logic [23:0] size, logic [31:0] ua);
			pending_q.push_back(m ? release_chunk(ua) : allocate(size));
		endfunction

		function void check_result(logic [2:0] st, logic [31:0] addr, logic [31:0] bytes);
			heap_result_t e;
			if (pending_q.size() == 0) begin
				$error("result beat with no request outstanding");
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (st !== e.st) begin
				$error("status: expected %0d, actual %0d", e.st, st);
				errors++;
			end
			if (addr !== e.addr) begin
				$error("result_addr: expected %h, actual %h", e.addr, addr);
				errors++;
			end
			if (bytes !== e.bytes) begin
				$error("chunk_bytes: expected %h, actual %h", e.bytes, bytes);
				errors++;
			end
		endfunction

		function logic [31:0] pick_live();
			int idx[$];
			foreach (live[i])
				if (live[i])
					idx.push_back(i);
			if (idx.size() == 0)
				return 32'd0;
			return 32'(live_start[idx[$urandom_range(0, idx.size() - 1)]] + HDR_BYTES);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 mode;
	logic [SIZE_W-1:0]    req_size;
	logic [31:0]          user_addr;
	logic                 out_valid;
	logic                 out_ready;
	logic [STATUS_W-1:0]  status;
	logic [OUT_W-1:0]     result_addr;
	logic [OUT_W-1:0]     chunk_bytes;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	heap_scoreboard sb = new();
	int hold_asks = 0;
	int burst_left = 0;

	first_fit_heap_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .req_size(req_size), .user_addr(user_addr),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .result_addr(result_addr), .chunk_bytes(chunk_bytes),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int holds_done, hold_cnt, cyc;
		bit eager;
		holds_done = 0;
		hold_cnt = 0;
		cyc = 0;
		eager = 0;
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result(status, result_addr, chunk_bytes);
			cyc++;
			if (cyc % 300 == 0)
				eager = $urandom_range(0, 1);
			if (hold_asks != holds_done) begin
				holds_done = hold_asks;
				hold_cnt = 2000;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 0;
			end else begin
				out_ready <= eager || ($urandom_range(0, 3) != 0);
			end
		end
	end

	task automatic send(logic m, logic [23:0] size, logic [31:0] ua);
		int gap;
		mode <= m;
		req_size <= size;
		user_addr <= ua;
		in_valid <= 1;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(m, size, ua);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 20);
			gap = $urandom_range(1, 8);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending_q.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_config(idx, data);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic random_request(int alloc_pct);
		int r;
		logic [31:0] p;
		logic [23:0] sz;
		r = $urandom_range(0, 99);
		p = sb.pick_live();
		case ($urandom_range(0, 9))
			0: sz = 24'($urandom);
			1, 2: sz = 24'($urandom_range(1, 65536));
			default: sz = 24'($urandom_range(1, 256));
		endcase
		if (r < 2)
			send(0, 24'd0, $urandom);
		else if (r < 4)
			send(1, 24'($urandom), 32'd0);
		else if (r < 6)
			send(1, 24'($urandom), $urandom);
		else if (r < 8 && p != 0)
			send(1, 24'($urandom), p + 32'd8 * $urandom_range(1, 3));
		else if (r < 8 + alloc_pct || p == 0)
			send(0, sz, $urandom);
		else
			send(1, 24'($urandom), p);
	endtask

	initial begin
		logic [31:0] bases[6];
		int grans[6], pcts[6];
		logic [31:0] p;
		bases = '{32'h0001_0000, 32'h0000_0000, 32'hFFF0_0000, 32'h8000_0000,
			32'hFFFF_FFFF, 32'h0001_0000};
		grans = '{22, 3, 0, 31, 24, 22};
		pcts = '{50, 55, 60, 80, 50, 45};
		arst_n = 0;
		in_valid = 0;
		mode = 0;
		req_size = 0;
		user_addr = 0;
		cfg_valid = 0;
		cfg_index = CFG_HEAP_BASE;
		cfg_data = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(0, 24'd0, 32'hFFFF_FFFF);
		send(1, 24'hFF_FFFF, 32'd0);
		send(1, 24'd0, 32'hFFFF_FFFF);
		send(1, 24'd0, 32'd4);
		send(0, 24'd1, 32'd0);
		send(0, 24'd16, 32'd0);
		send(0, 24'd17, 32'd0);
		send(0, 24'd24, 32'd0);
		send(0, 24'hFF_FFFF, 32'd0);
		send(0, 24'd100, 32'd0);
		for (int i = 0; i < 6; i++) begin
			p = sb.pick_live();
			send(1, 24'd0, p);
		end
		send(1, 24'd0, 32'd8);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_HEAP_BASE, ph == 3 ? bases[ph] | ($urandom & 32'h0FFF_FFF8)
				: bases[ph]);
			write_reg(CFG_GRANULE_LOG2, grans[ph]);
			for (int n = 0; n < 340; n++) begin
				if (ph == 1 && n == 60)
					hold_asks++;
				if (ph == 2 && n == 120)
					drain();
				random_request(pcts[ph]);
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
